### src/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// Used by the interfaces, the controller, the datapath and the top level.
package mme_pkg;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 4;
	localparam int VAL_W     = 16;
	localparam int DIM_W     = 5;
	localparam int SUM_W     = 36;
	localparam int CALC_W    = 12;
	localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ISSUE = 2'd1,
		ST_DRAIN = 2'd2
	} state_t;

	typedef struct packed {
		logic start;
		logic we_a;
		logic we_b;
		logic issue;
		logic load_out;
		logic load_acc;
		logic out_is_product;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_write_a;
		logic is_write_b;
		logic in_range;
		logic terms_zero;
		logic last;
		logic busy;
	} sts_t;

endpackage

### src/mme_req_if.sv
// Request channel: one beat writes an A or B element or asks for a C element.
// Depends on mme_pkg for field widths.
interface mme_req_if;
	logic                            valid;
	logic                            ready;
	logic [mme_pkg::OP_W-1:0]        operation;
	logic [mme_pkg::IDX_W-1:0]       row;
	logic [mme_pkg::IDX_W-1:0]       column;
	logic signed [mme_pkg::VAL_W-1:0] element_value;

	modport source (output valid, output operation, output row, output column,
		output element_value, input ready);
	modport sink (input valid, input operation, input row, input column,
		input element_value, output ready);
endinterface

### src/mme_rsp_if.sv
// Response channel: one beat per request, carrying the product or an ack.
// Depends on mme_pkg for field widths.
interface mme_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             is_product;
	logic signed [mme_pkg::SUM_W-1:0] product_sum;

	modport source (output valid, output is_product, output product_sum,
		input ready);
	modport sink (input valid, input is_product, input product_sum,
		output ready);
endinterface

### src/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: controller plus datapath.
// Depends on mme_pkg, mme_req_if, mme_rsp_if, mme_ctrl and mme_dp.
//
// Each request beat writes one element of A or B, or reads one element of
// C = A x B as the signed dot product of an A row and a B column over
// min(dimension, MAX_DIM) terms, wrapped to 36 bits. Every request yields
// exactly one response beat. A write, an out-of-range read or a read with
// zero terms has its response in the cycle after it is taken. A read in range
// is worked by one multiply-accumulate unit that issues one term per cycle,
// fed by one read port on each element store; the drain state then waits for
// the multiply and accumulate stages to empty and for the output register to
// be free before loading it, and the next request is taken only back in idle.
// A finished response is held in an output register, and a new request
// is taken only once that response is gone or leaves in the same cycle. The
// stores are not cleared at reset; read only elements that were written.
module matrix_multiply_engine #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mme_pkg::DIM_W-1:0]   cfg_wdata,
	mme_req_if.sink                     req,
	mme_rsp_if.source                   rsp
);

	mme_pkg::cmd_t cmd;
	mme_pkg::sts_t sts;

	mme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mme_dp #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (req.operation),
		.row           (req.row),
		.column        (req.column),
		.element_value (req.element_value),
		.cmd           (cmd),
		.sts           (sts),
		.is_product    (rsp.is_product),
		.product_sum   (rsp.product_sum)
	);

endmodule

### src/mme_ctrl.sv
// Controller state machine of the matrix multiply engine.
// Depends on mme_pkg for state, command and status types.
module mme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  mme_pkg::sts_t     sts,
	output mme_pkg::cmd_t     cmd
);

	mme_pkg::state_t state_q;
	mme_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;
	logic            fire;
	logic            run_read;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == mme_pkg::ST_IDLE) && slot_free;
	assign fire      = req_valid && req_ready;
	assign run_read  = sts.is_read && sts.in_range && !sts.terms_zero;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (fire && run_read) begin
					state_d = mme_pkg::ST_ISSUE;
				end
			end
			mme_pkg::ST_ISSUE: begin
				if (sts.last) begin
					state_d = mme_pkg::ST_DRAIN;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (!sts.busy && slot_free) begin
					state_d = mme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				cmd.we_a           = fire && sts.is_write_a && sts.in_range;
				cmd.we_b           = fire && sts.is_write_b && sts.in_range;
				cmd.start          = fire && run_read;
				cmd.load_out       = fire && !run_read;
				cmd.out_is_product = sts.is_read;
			end
			mme_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
			end
			mme_pkg::ST_DRAIN: begin
				cmd.load_out       = !sts.busy && slot_free;
				cmd.load_acc       = 1'b1;
				cmd.out_is_product = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mme_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/mme_dp.sv
// Datapath: element stores, multiply-accumulate pipeline and result register.
// Depends on mme_pkg for widths and the command and status types.
module mme_dp #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mme_pkg::DIM_W-1:0]           cfg_wdata,
	input  logic [mme_pkg::OP_W-1:0]            operation,
	input  logic [mme_pkg::IDX_W-1:0]           row,
	input  logic [mme_pkg::IDX_W-1:0]           column,
	input  logic signed [mme_pkg::VAL_W-1:0]    element_value,
	input  mme_pkg::cmd_t                       cmd,
	output mme_pkg::sts_t                       sts,
	output logic                                is_product,
	output logic signed [mme_pkg::SUM_W-1:0]    product_sum
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = $clog2(MAX_DIM + 1);
	localparam int SW    = (ELEM_WIDTH < mme_pkg::VAL_W) ? ELEM_WIDTH : mme_pkg::VAL_W;
	localparam int PW    = 2 * ELEM_WIDTH;

	logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

	logic [mme_pkg::DIM_W-1:0]    dim_q;
	logic [TW-1:0]                terms;
	logic [TW-1:0]                k_q;
	logic [mme_pkg::IDX_W-1:0]    row_q;
	logic [mme_pkg::IDX_W-1:0]    col_q;
	logic [mme_pkg::CALC_W-1:0]   wr_full;
	logic [mme_pkg::CALC_W-1:0]   ra_full;
	logic [mme_pkg::CALC_W-1:0]   rb_full;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                ra_addr;
	logic [AW-1:0]                rb_addr;
	logic signed [ELEM_WIDTH-1:0] wr_elem;
	logic signed [ELEM_WIDTH-1:0] a_s1;
	logic signed [ELEM_WIDTH-1:0] b_s1;
	logic signed [PW-1:0]         prod_s2;
	logic                         vld_s1;
	logic                         vld_s2;
	logic signed [mme_pkg::SUM_W-1:0] acc_q;
	logic                         is_product_q;
	logic signed [mme_pkg::SUM_W-1:0] sum_q;
	mme_pkg::op_t                 op;

	assign op = mme_pkg::op_t'(operation);

	always_comb begin
		if (mme_pkg::CALC_W'(dim_q) > mme_pkg::CALC_W'(MAX_DIM)) begin
			terms = TW'(MAX_DIM);
		end else begin
			terms = TW'(dim_q);
		end
	end

	assign wr_full = mme_pkg::CALC_W'(row) * mme_pkg::CALC_W'(MAX_DIM)
		+ mme_pkg::CALC_W'(column);
	assign ra_full = mme_pkg::CALC_W'(row_q) * mme_pkg::CALC_W'(MAX_DIM)
		+ mme_pkg::CALC_W'(k_q);
	assign rb_full = mme_pkg::CALC_W'(k_q) * mme_pkg::CALC_W'(MAX_DIM)
		+ mme_pkg::CALC_W'(col_q);
	assign wr_addr = wr_full[AW-1:0];
	assign ra_addr = ra_full[AW-1:0];
	assign rb_addr = rb_full[AW-1:0];
	assign wr_elem = ELEM_WIDTH'($signed(element_value[SW-1:0]));

	always_comb begin
		sts            = '0;
		sts.is_write_a = (op == mme_pkg::OP_WRITE_A);
		sts.is_write_b = (op == mme_pkg::OP_WRITE_B);
		sts.is_read    = (op == mme_pkg::OP_READ);
		sts.in_range   = (mme_pkg::CALC_W'(row) < mme_pkg::CALC_W'(MAX_DIM))
			&& (mme_pkg::CALC_W'(column) < mme_pkg::CALC_W'(MAX_DIM));
		sts.terms_zero = (terms == '0);
		sts.last       = (k_q == terms - TW'(1));
		sts.busy       = vld_s1 || vld_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.we_a) begin
			mem_a[wr_addr] <= wr_elem;
		end
		if (cmd.we_b) begin
			mem_b[wr_addr] <= wr_elem;
		end
		a_s1 <= mem_a[ra_addr];
		b_s1 <= mem_b[rb_addr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (cmd.start) begin
			row_q <= row;
			col_q <= column;
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + mme_pkg::SUM_W'(prod_s2);
		end
		if (cmd.load_out) begin
			is_product_q <= cmd.out_is_product;
			sum_q        <= cmd.load_acc ? acc_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= mme_pkg::DIM_RESET;
			k_q    <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				dim_q <= cfg_wdata;
			end
			if (cmd.start) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + TW'(1);
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	assign is_product  = is_product_q;
	assign product_sum = sum_q;

endmodule

### bench/matrix_multiply_engine_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the matrix multiply engine: watches the configuration, request
// and response ports, predicts every response beat and compares it field by field.
// Depends on mme_pkg, mme_req_if and mme_rsp_if.
module matrix_multiply_engine_checker #(
	parameter int MAX_DIM = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mme_pkg::DIM_W-1:0] cfg_wdata,
	mme_req_if                        req,
	mme_rsp_if                        rsp,
	output int                        errors,
	output int                        outstanding,
	output int                        products
);

	typedef struct {
		logic                             is_product;
		logic signed [mme_pkg::SUM_W-1:0] product_sum;
	} answer_t;

	logic signed [mme_pkg::VAL_W-1:0] a_elems [MAX_DIM*MAX_DIM];
	logic signed [mme_pkg::VAL_W-1:0] b_elems [MAX_DIM*MAX_DIM];
	logic [mme_pkg::DIM_W-1:0]        dim_setting;
	answer_t                          pending_answers [$];

	function automatic answer_t dot_product(int r, int c);
		answer_t ans;
		int terms;
		ans.is_product = 1'b1;
		ans.product_sum = '0;
		terms = (dim_setting > MAX_DIM) ? MAX_DIM : int'(dim_setting);
		for (int k = 0; k < terms; k++)
			ans.product_sum = ans.product_sum
				+ a_elems[r*MAX_DIM+k] * b_elems[k*MAX_DIM+c];
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			pending_answers.delete();
			dim_setting = mme_pkg::DIM_RESET;
			errors = 0;
			outstanding = 0;
			products = 0;
		end else begin
			if (cfg_we)
				dim_setting = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (pending_answers.size() == 0) begin
					$error("response beat with no request waiting: is_product %0b product_sum %0d",
						rsp.is_product, rsp.product_sum);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp.is_product !== want.is_product) begin
						$error("is_product: expected %0b, actual %0b",
							want.is_product, rsp.is_product);
						errors++;
					end
					if (rsp.product_sum !== want.product_sum) begin
						$error("product_sum: expected %0d, actual %0d",
							want.product_sum, rsp.product_sum);
						errors++;
					end
					if (want.is_product)
						products++;
				end
			end
			if (req.valid && req.ready) begin
				got.is_product = 1'b0;
				got.product_sum = '0;
				case (req.operation)
					mme_pkg::OP_WRITE_A:
						a_elems[int'(req.row)*MAX_DIM+int'(req.column)] = req.element_value;
					mme_pkg::OP_WRITE_B:
						b_elems[int'(req.row)*MAX_DIM+int'(req.column)] = req.element_value;
					mme_pkg::OP_READ:
						got = dot_product(int'(req.row), int'(req.column));
					default:    ;
				endcase
				pending_answers.push_back(got);
			end
			outstanding = pending_answers.size();
		end
	end

endmodule

### bench/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps
// Top of the matrix multiply engine bench: clock, reset, dimension writes and
// request traffic with bursts and response stalls; the scoreboard does the checking.
// Depends on mme_pkg, mme_req_if, mme_rsp_if, the engine and its checker.
module matrix_multiply_engine_tb;

	localparam int MAX_DIM = 16;
	localparam int PHASE_BEATS = 105;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [mme_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum int {
		RDY_ALWAYS,
		RDY_MOSTLY,
		RDY_RARELY,
		RDY_PERIODIC
	} ready_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [mme_pkg::DIM_W-1:0] cfg_wdata = '0;
	int                        errors;
	int                        outstanding;
	int                        products;
	int                        cycles = 0;
	int                        beats_sent = 0;
	int                        burst_left = 0;
	int                        mode_left = 0;
	int                        ready_tick = 0;
	ready_mode_t               ready_mode = RDY_ALWAYS;
	logic [mme_pkg::DIM_W-1:0] dim_now = mme_pkg::DIM_RESET;
	bit                        a_written [MAX_DIM*MAX_DIM];
	bit                        b_written [MAX_DIM*MAX_DIM];
	logic [mme_pkg::DIM_W-1:0] phase_dims [11] = '{5'd0, 5'd1, 5'd3, 5'd2, 5'd5, 5'd16,
		5'd31, 5'd17, 5'd4, 5'd8, 5'd16};

	mme_req_if req_ch();
	mme_rsp_if rsp_ch();

	matrix_multiply_engine #(
		.MAX_DIM(MAX_DIM),
		.ELEM_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	matrix_multiply_engine_checker #(
		.MAX_DIM(MAX_DIM)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch),
		.errors(errors),
		.outstanding(outstanding),
		.products(products)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycles, outstanding);
			$display("matrix_multiply_engine: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 300);
		end
		mode_left--;
		ready_tick++;
		case (ready_mode)
			RDY_ALWAYS:   rsp_ch.ready = 1'b1;
			RDY_MOSTLY:   rsp_ch.ready = ($urandom_range(0, 3) != 0);
			RDY_RARELY:   rsp_ch.ready = ($urandom_range(0, 3) == 0);
			default:      rsp_ch.ready = ((ready_tick % 5) != 4);
		endcase
	end

	function automatic logic signed [mme_pkg::VAL_W-1:0] any_value();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			default: return mme_pkg::VAL_W'($urandom);
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(logic [mme_pkg::OP_W-1:0] op, int r, int c,
		logic signed [mme_pkg::VAL_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid = 1'b1;
		req_ch.operation = op;
		req_ch.row = mme_pkg::IDX_W'(r);
		req_ch.column = mme_pkg::IDX_W'(c);
		req_ch.element_value = v;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		beats_sent++;
		if (op == mme_pkg::OP_WRITE_A)
			a_written[r*MAX_DIM+c] = 1'b1;
		if (op == mme_pkg::OP_WRITE_B)
			b_written[r*MAX_DIM+c] = 1'b1;
	endtask

	// fill any missing A row or B column terms first, then ask for the product
	task automatic read_product(int r, int c);
		int terms;
		terms = (dim_now > MAX_DIM) ? MAX_DIM : int'(dim_now);
		for (int k = 0; k < terms; k++) begin
			if (!a_written[r*MAX_DIM+k])
				send_beat(mme_pkg::OP_WRITE_A, r, k, any_value());
			if (!b_written[k*MAX_DIM+c])
				send_beat(mme_pkg::OP_WRITE_B, k, c, any_value());
		end
		send_beat(mme_pkg::OP_READ, r, c, mme_pkg::VAL_W'($urandom));
	endtask

	task automatic set_dimension(logic [mme_pkg::DIM_W-1:0] d);
		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (MAX_DIM + 4) @(negedge clk);
		cfg_wdata = d;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		dim_now = d;
	endtask

	initial begin
		int start;
		req_ch.valid = 1'b0;
		req_ch.operation = mme_pkg::OP_WRITE_A;
		req_ch.row = '0;
		req_ch.column = '0;
		req_ch.element_value = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_dimension(5'd2);
		send_beat(mme_pkg::OP_WRITE_A, 0, 0, 16'sh8000);
		send_beat(mme_pkg::OP_WRITE_A, 0, 1, 16'sh7fff);
		send_beat(mme_pkg::OP_WRITE_A, 15, 0, 16'sh8000);
		send_beat(mme_pkg::OP_WRITE_A, 15, 1, 16'sh8000);
		send_beat(mme_pkg::OP_WRITE_B, 0, 0, 16'sh8000);
		send_beat(mme_pkg::OP_WRITE_B, 1, 0, 16'sh7fff);
		send_beat(mme_pkg::OP_WRITE_B, 0, 15, 16'sh8000);
		send_beat(mme_pkg::OP_WRITE_B, 1, 15, 16'sh8000);
		read_product(0, 0);
		read_product(15, 15);
		read_product(0, 15);
		read_product(15, 0);
		send_beat(OP_UNUSED, 15, 15, 16'shffff);
		send_beat(OP_UNUSED, 0, 0, 16'sh0000);
		read_product(15, 15);
		send_beat(mme_pkg::OP_WRITE_A, 0, 0, 16'sh0000);
		read_product(0, 0);

		foreach (phase_dims[p]) begin
			set_dimension(phase_dims[p]);
			start = beats_sent;
			while (beats_sent - start < PHASE_BEATS) begin
				case ($urandom_range(0, 19))
					0: send_beat(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
						any_value());
					1, 2, 3, 4, 5: send_beat(
						$urandom_range(0, 1) ? mme_pkg::OP_WRITE_B : mme_pkg::OP_WRITE_A,
						$urandom_range(0, 15), $urandom_range(0, 15), any_value());
					default: read_product($urandom_range(0, 15), $urandom_range(0, 15));
				endcase
			end
		end

		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (MAX_DIM + 8) @(negedge clk);
		$display("%0d request beats sent, %0d product reads checked", beats_sent, products);
		$display("dimension swept over %0d settings from 0 up to 31 with random stalls",
			$size(phase_dims) + 1);
		if (errors == 0 && outstanding == 0)
			$display("matrix_multiply_engine: match");
		else
			$display("matrix_multiply_engine: mismatch");
		$finish;
	end

endmodule

### files.f
src/mme_pkg.sv
src/mme_req_if.sv
src/mme_rsp_if.sv
src/mme_ctrl.sv
src/mme_dp.sv
src/matrix_multiply_engine.sv
bench/matrix_multiply_engine_checker.sv
bench/matrix_multiply_engine_tb.sv
